### design/sha_pkg.sv
`timescale 1ns / 1ps
// SHA-256 package: round constants, initial hash values, round functions
// and the sequencer state type. No dependencies.
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;

  localparam logic [WordW-1:0] SHA_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WordW-1:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_FF,
    ST_DBL,
    ST_OUT
  } sha_state_e;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### design/sha_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for message words and digest words.
// No dependencies.
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

### design/sha256_stream_hasher_core.sv
`timescale 1ns / 1ps
// SHA-256 / SHA-256d stream hasher: one shared round unit under a sequencer.
// Each accepted word is packed one byte a cycle (up to 4 bytes), pausing while a full
// block is compressed (64 rounds, then feed-forward). A last word then gets padding,
// the length and up to two compressions, one more compression in double mode, then
// 8 digest words. Ready only in idle. Reset (rst_ni low, async) restores the initial hash.
module sha256_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  sha_in_if.sink      in_if,
  sha_out_if.source   out_if
);
  import sha_pkg::*;

  sha_state_e  state_q, state_d;
  sha_state_e  ret_q, ret_d;         // where to resume after feed-forward
  logic        mode_q, mode_d;       // double_mode register
  logic        snap_q, snap_d;       // mode taken with the last word
  logic        dbl_q, dbl_d;         // second pass of SHA-256d running
  logic        pad80_q, pad80_d;     // 0x80 byte still to place
  logic [5:0]  pos_q, pos_d;
  logic [60:0] len_q, len_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  oidx_q, oidx_d;
  logic [31:0] chain_q [8];
  logic [31:0] chain_d [8];

  // Payload state: no reset needed.
  logic [31:0] blk_q [16];
  logic [31:0] blk_d [16];
  logic [31:0] wv_q [8];
  logic [31:0] wv_d [8];
  logic [31:0] hword_q, hword_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic        hlast_q, hlast_d;

  logic        in_acc, out_acc;
  logic        push_en;
  logic [7:0]  push_byte;
  logic [2:0]  cnt_sat;
  logic [31:0] t1, t2, w_new;
  logic [63:0] bit_len;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;
  assign cnt_sat = (in_if.valid_bytes > 3'd4) ? 3'd4 : in_if.valid_bytes;
  assign bit_len = {len_q, 3'b000};

  // Round unit and schedule extension.
  always_comb begin
    t1 = wv_q[7] + big_s1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
       + SHA_K[rnd_q] + blk_q[0];
    t2 = big_s0(wv_q[0])
       + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
    w_new = small_s1(blk_q[14]) + blk_q[9] + small_s0(blk_q[1]) + blk_q[0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_PUSH;
      ST_PUSH: begin
        if (hcnt_q == 3'd0) state_d = hlast_q ? ST_PAD : ST_IDLE;
        else if (pos_q == 6'd63) state_d = ST_COMP;
      end
      ST_PAD: begin
        if (!pad80_q && pos_q == 6'd56) state_d = ST_LEN;
        else if (pos_q == 6'd63) state_d = ST_COMP;
      end
      ST_LEN:  state_d = ST_COMP;
      ST_COMP: if (rnd_q == 6'd63) state_d = ST_FF;
      ST_FF: begin
        if (ret_q == ST_OUT) state_d = (snap_q && !dbl_q) ? ST_DBL : ST_OUT;
        else state_d = ret_q;
      end
      ST_DBL:  state_d = ST_COMP;
      ST_OUT:  if (out_acc && oidx_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and bookkeeping.
  always_comb begin
    ret_d   = ret_q;
    mode_d  = cfg_we_i ? cfg_wdata_i : mode_q;
    snap_d  = snap_q;
    dbl_d   = dbl_q;
    pad80_d = pad80_q;
    pos_d   = pos_q;
    len_d   = len_q;
    rnd_d   = rnd_q;
    oidx_d  = oidx_q;
    chain_d = chain_q;
    blk_d   = blk_q;
    wv_d    = wv_q;
    hword_d = hword_q;
    hcnt_d  = hcnt_q;
    hlast_d = hlast_q;
    push_en   = 1'b0;
    push_byte = hword_q[31:24];

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          hword_d = in_if.message_word;
          hcnt_d  = cnt_sat;
          hlast_d = in_if.last_word;
          len_d   = len_q + 61'(cnt_sat);
          snap_d  = mode_q;
        end
      end
      ST_PUSH: begin
        if (hcnt_q == 3'd0) begin
          pad80_d = 1'b1;
        end else begin
          push_en = 1'b1;
          hword_d = {hword_q[23:0], 8'h00};
          hcnt_d  = hcnt_q - 3'd1;
          ret_d   = ST_PUSH;
        end
      end
      ST_PAD: begin
        if (pad80_q || pos_q != 6'd56) begin
          push_en   = 1'b1;
          push_byte = pad80_q ? PadByte : 8'h00;
          pad80_d   = 1'b0;
          ret_d     = ST_PAD;
        end
      end
      ST_LEN: begin
        blk_d[14] = bit_len[63:32];
        blk_d[15] = bit_len[31:0];
        pos_d = '0;
        ret_d = ST_OUT;
        wv_d  = chain_q;
        rnd_d = '0;
      end
      ST_COMP: begin
        // advance one round and slide the schedule window
        for (int i = 0; i < 15; i++) blk_d[i] = blk_q[i+1];
        blk_d[15] = w_new;
        wv_d[7] = wv_q[6];
        wv_d[6] = wv_q[5];
        wv_d[5] = wv_q[4];
        wv_d[4] = wv_q[3] + t1;
        wv_d[3] = wv_q[2];
        wv_d[2] = wv_q[1];
        wv_d[1] = wv_q[0];
        wv_d[0] = t1 + t2;
        rnd_d = rnd_q + 6'd1;
      end
      ST_FF: begin
        for (int i = 0; i < 8; i++) chain_d[i] = chain_q[i] + wv_q[i];
      end
      ST_DBL: begin
        // the 32-byte digest fits one padded block; its length is 256 bits
        for (int i = 0; i < 8; i++) blk_d[i] = chain_q[i];
        blk_d[8] = {PadByte, 24'h0};
        for (int i = 9; i < 15; i++) blk_d[i] = '0;
        blk_d[15] = 32'd256;
        chain_d = SHA_IV;
        wv_d    = SHA_IV;
        rnd_d   = '0;
        dbl_d   = 1'b1;
        ret_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            chain_d = SHA_IV;
            len_d   = '0;
            pos_d   = '0;
            dbl_d   = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // Byte packer: drop one byte into the block, compress when it fills.
    if (push_en) begin
      blk_d[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] = push_byte;
      pos_d = pos_q + 6'd1;
      if (pos_q == 6'd63) begin
        wv_d  = chain_q;
        rnd_d = '0;
      end
    end
  end

  // Port outputs.
  always_comb begin
    in_if.ready         = (state_q == ST_IDLE);
    out_if.valid        = (state_q == ST_OUT);
    out_if.digest_word  = chain_q[oidx_q];
    out_if.digest_index = oidx_q;
    out_if.digest_last  = (oidx_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      mode_q  <= 1'b0;
      snap_q  <= 1'b0;
      dbl_q   <= 1'b0;
      pad80_q <= 1'b0;
      pos_q   <= '0;
      len_q   <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      chain_q <= SHA_IV;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      mode_q  <= mode_d;
      snap_q  <= snap_d;
      dbl_q   <= dbl_d;
      pad80_q <= pad80_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q   <= blk_d;
    wv_q    <= wv_d;
    hword_q <= hword_d;
    hcnt_q  <= hcnt_d;
    hlast_q <= hlast_d;
  end

  // Checks.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid))
    else $error("input ready while digest pending");

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && rnd_q == 6'd63) |=> (state_q == ST_FF))
    else $error("compression did not end after 64 rounds");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_if.digest_last) |=> (in_if.ready && pos_q == 6'd0))
    else $error("not idle after final digest word");

endmodule

### sim/sha256_stream_hasher_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sha256_stream_hasher_core: directed table, then random messages,
// every digest word checked against a SHA-256 / SHA-256d predictor kept in the bench.
// Depends on sha_pkg, sha_in_if and sha_out_if.
module sha256_stream_hasher_core_test;
  import sha_pkg::*;

  localparam int unsigned RandWords = 280;
  localparam int unsigned SettleCycles = 400;

  // mode request carried by a table row
  localparam logic [1:0] MODE_KEEP   = 2'd0;
  localparam logic [1:0] MODE_PLAIN  = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] msg;
    logic [2:0]  nbytes;
    logic        last;
    logic        known;     // first digest word typed in below
    logic [31:0] first_word;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_stream_hasher_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [5:0]  fill;
  logic [60:0] msg_len;
  logic        dbl_mode;

  digest_beat_t digest_q [$];
  int unsigned  errors = 0;
  bit           quiet = 1'b0;

  stim_row_t table_rows [] = '{
    // empty message, plain
    '{MODE_PLAIN, 32'h0, 3'd0, 1'b1, 1'b1, 32'he3b0c442},
    // "abc"
    '{MODE_KEEP, 32'h61626300, 3'd3, 1'b1, 1'b1, 32'hba7816bf},
    // over-long byte count, then partial words ahead of the end
    '{MODE_KEEP, 32'hffffffff, 3'd7, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'h12345678, 3'd1, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'h00000000, 3'd4, 1'b1, 1'b0, 32'h0},
    // 56 bytes: padding spills into a second block
    '{MODE_KEEP, 32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'h00000000, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'h00000000, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'ha5a5a5a5, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'h5a5a5a5a, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'h00000000, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'h00000000, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'hffffffff, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'h80000001, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'h7ffffffe, 3'd4, 1'b0, 1'b0, 32'h0},
    '{MODE_KEEP, 32'h0, 3'd0, 1'b1, 1'b0, 32'h0},
    // double mode: empty message and a full last word
    '{MODE_DOUBLE, 32'h0, 3'd0, 1'b1, 1'b0, 32'h0},
    '{MODE_KEEP, 32'hdeadbeef, 3'd6, 1'b1, 1'b0, 32'h0},
    '{MODE_PLAIN, 32'h0, 3'd0, 1'b1, 1'b1, 32'he3b0c442}
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one compression of the block buffer into the chain value
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, x15, x2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        x15 = w[(r - 15) & 15];
        x2  = w[(r - 2) & 15];
        wt = w[r & 15] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + w[(r - 7) & 15]
           + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
        w[r & 15] = wt;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void pack_byte(input logic [7:0] b);
    blk[fill[5:2]][24 - 8 * fill[1:0] +: 8] = b;
    if (fill == 6'd63) begin
      compress_block();
    end
    fill = fill + 6'd1;
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
    fill = '0;
    msg_len = '0;
  endfunction

  function automatic void pad_and_close();
    logic [63:0] bits;
    bits = {msg_len, 3'b000};
    pack_byte(PadByte);
    if (fill > 6'd56) begin
      while (fill != 6'd0) pack_byte(8'h00);
    end
    while (fill < 6'd56) pack_byte(8'h00);
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    compress_block();
    fill = '0;
  endfunction

  // advance the predictor by one accepted word; queue the digest on a last word
  function automatic void predict_digest(input stim_row_t row);
    int unsigned n;
    logic [31:0] first [8];
    n = (row.nbytes > 3'd4) ? 4 : row.nbytes;
    for (int i = 0; i < n; i++) pack_byte(row.msg[31 - 8 * i -: 8]);
    msg_len = msg_len + 61'(n);
    if (row.last) begin
      pad_and_close();
      if (dbl_mode) begin
        for (int i = 0; i < 8; i++) first[i] = chain[i];
        restart_message();
        for (int i = 0; i < 8; i++)
          for (int k = 0; k < 4; k++) pack_byte(first[i][31 - 8 * k -: 8]);
        msg_len = 61'd32;
        pad_and_close();
      end
      for (int i = 0; i < 8; i++)
        digest_q.push_back('{(i == 0 && row.known) ? row.first_word : chain[i], 3'(i), i == 7});
      restart_message();
    end
  endfunction

  // wait for the block to drain, then write the mode register
  task automatic write_mode(input logic m);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dbl_mode = m;
  endtask

  // drive one word and hold it until accepted; valid stays high afterwards unless a random gap drops it
  task automatic send_word(input stim_row_t row);
    in_if.valid <= 1'b1;
    in_if.message_word <= row.msg;
    in_if.valid_bytes <= row.nbytes;
    in_if.last_word <= row.last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_digest(row);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // sink side: check each accepted digest word, stall in random bursts
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    digest_beat_t exp_beat;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected digest word %h idx %0d", out_if.digest_word, out_if.digest_index);
      end else begin
        exp_beat = digest_q.pop_front();
        if (out_if.digest_word !== exp_beat.word || out_if.digest_index !== exp_beat.index ||
            out_if.digest_last !== exp_beat.last) begin
          errors++;
          if (errors <= 10)
            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b", exp_beat.word,
                     exp_beat.index, exp_beat.last, out_if.digest_word, out_if.digest_index,
                     out_if.digest_last);
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= (stall_left == 0);
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    stim_row_t row;
    int unsigned sent;
    int unsigned msg_words;
    in_if.valid = 1'b0;
    in_if.message_word = '0;
    in_if.valid_bytes = '0;
    in_if.last_word = 1'b0;
    out_if.ready = 1'b0;
    dbl_mode = 1'b0;
    restart_message();
    for (int i = 0; i < 16; i++) blk[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (table_rows[i]) begin
      if (table_rows[i].mode != MODE_KEEP) begin
        in_if.valid <= 1'b0;
        write_mode(table_rows[i].mode == MODE_DOUBLE);
      end
      send_word(table_rows[i]);
    end

    // random messages, mostly full words with a ragged last word
    sent = 0;
    while (sent < RandWords) begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        in_if.valid <= 1'b0;
        write_mode(1'($urandom_range(0, 1)));
      end
      msg_words = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 18);
      for (int w = 0; w <= msg_words; w++) begin
        if (sent > RandWords - 50) quiet = 1'b1;
        row.mode = MODE_KEEP;
        row.msg = $urandom;
        row.last = (w == msg_words);
        row.known = 1'b0;
        row.first_word = '0;
        if (row.last || $urandom_range(0, 15) == 0) row.nbytes = 3'($urandom_range(0, 7));
        else row.nbytes = 3'd4;
        // occasionally flip the mode mid-message; it is taken at the last word
        if (!quiet && !row.last && w != 0 && $urandom_range(0, 40) == 0) begin
          in_if.valid <= 1'b0;
          write_mode(1'($urandom_range(0, 1)));
        end
        send_word(row);
        sent++;
      end
    end
    in_if.valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
design/sha_pkg.sv
design/sha_if.sv
design/sha256_stream_hasher_core.sv
sim/sha256_stream_hasher_core_test.sv
